>>> rtl/trilinear_table_interpolator_top_defines.svh
// Assertion macros shared by the trilinear interpolator RTL.
// Depends on nothing; files that check their own logic include it.
`ifndef TRILINEAR_TABLE_INTERPOLATOR_TOP_DEFINES_SVH
`define TRILINEAR_TABLE_INTERPOLATOR_TOP_DEFINES_SVH
`ifndef SYNTH
`define TRI_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define TRI_ASSERT_I(lbl, prop, msg) `TRI_ASSERT(lbl, clk_i, rst_ni, prop, msg)
`else
`define TRI_ASSERT(lbl, clk, rst_n, prop, msg)
`define TRI_ASSERT_I(lbl, prop, msg)
`endif
`endif

>>> rtl/trilin_pkg.sv
// Shared widths, default parameters and operation codes of the trilinear interpolator.
// Depends on nothing.
`default_nettype none

package trilin_pkg;

  localparam int unsigned IDX_W     = 4;
  localparam int unsigned VAL_W     = 32;
  localparam int unsigned FRAC_IN_W = 17;
  localparam int unsigned NUM_BANKS = 8;

  localparam int unsigned DIM_X_DEF     = 16;
  localparam int unsigned DIM_Y_DEF     = 16;
  localparam int unsigned DIM_Z_DEF     = 16;
  localparam int unsigned FRAC_BITS_DEF = 16;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

endpackage

`default_nettype wire

>>> rtl/trilin_ram.sv
// Simple dual-port RAM with one write port and one registered read port.
// Depends on nothing.
`default_nettype none

module trilin_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 512
) (
  input  wire logic                       clk_i,
  input  wire logic                       we_i,
  input  wire logic [$clog2(DEPTH)-1:0]   waddr_i,
  input  wire logic [WIDTH-1:0]           wdata_i,
  input  wire logic                       re_i,
  input  wire logic [$clog2(DEPTH)-1:0]   raddr_i,
  output logic      [WIDTH-1:0]           rdata_o
);

  localparam int unsigned AW = $clog2(DEPTH);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;
  logic [AW-1:0]    raddr;

  assign raddr   = raddr_i;
  assign rdata_o = rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr];
    end
  end

endmodule

`default_nettype wire

>>> rtl/trilin_blend.sv
// One linear blend a + (b - a) * f over two register stages: multiply, then round and saturate.
// Depends on trilin_pkg.
`default_nettype none

module trilin_blend #(
  parameter int unsigned FRAC_BITS = trilin_pkg::FRAC_BITS_DEF
) (
  input  wire logic                                clk_i,
  input  wire logic                                mul_en_i,
  input  wire logic                                rnd_en_i,
  input  wire logic signed [trilin_pkg::VAL_W-1:0] a_i,
  input  wire logic signed [trilin_pkg::VAL_W-1:0] b_i,
  input  wire logic        [FRAC_BITS:0]           frac_i,
  output logic      signed [trilin_pkg::VAL_W-1:0] result_o
);

  import trilin_pkg::*;

  localparam int unsigned FW = FRAC_BITS + 1;
  localparam int unsigned DW = VAL_W + 1;
  localparam int unsigned PW = DW + FW + 1;
  localparam int unsigned QW = PW - FRAC_BITS;
  localparam int unsigned SW = QW + 1;

  localparam logic signed [PW-1:0] HALF  = PW'(1) << (FRAC_BITS - 1);
  localparam logic signed [SW-1:0] MAX_V = {{(SW-VAL_W+1){1'b0}}, {(VAL_W-1){1'b1}}};
  localparam logic signed [SW-1:0] MIN_V = {{(SW-VAL_W+1){1'b1}}, {(VAL_W-1){1'b0}}};

  logic signed [DW-1:0]    diff;
  logic signed [PW-1:0]    prod_d;
  logic signed [PW-1:0]    prod_q;
  logic signed [VAL_W-1:0] a_q;
  logic signed [PW-1:0]    biased;
  logic signed [QW-1:0]    quot;
  logic signed [SW-1:0]    sum;
  logic signed [VAL_W-1:0] res_d;
  logic signed [VAL_W-1:0] res_q;

  assign diff   = {b_i[VAL_W-1], b_i} - {a_i[VAL_W-1], a_i};
  assign prod_d = PW'(diff) * PW'(signed'({1'b0, frac_i}));

  always_ff @(posedge clk_i) begin
    if (mul_en_i) begin
      a_q    <= a_i;
      prod_q <= prod_d;
    end
  end

  assign biased = prod_q + HALF;
  assign quot   = QW'(biased >>> FRAC_BITS);
  assign sum    = SW'(a_q) + SW'(quot);

  always_comb begin
    if (sum > MAX_V) begin
      res_d = MAX_V[VAL_W-1:0];
    end else if (sum < MIN_V) begin
      res_d = MIN_V[VAL_W-1:0];
    end else begin
      res_d = sum[VAL_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (rnd_en_i) begin
      res_q <= res_d;
    end
  end

  assign result_o = res_q;

endmodule

`default_nettype wire

>>> rtl/trilinear_table_interpolator_top.sv
// Trilinear interpolator over a 3D table of signed Q16.16 entries. A write request stores one
// entry when its indices are in range and returns nothing; a query request names the upper
// corner and three fractions and returns one result. The table sits in eight RAM banks selected
// by the parity of each index, so the eight corners of any query are read in the same cycle.
// The block takes one request per cycle while the result channel does not stall. A query passes
// the bank read register, then the x, y and z blend stages (multiply, then round and saturate).
// Table entries hold no defined value until written, and there is no clearing pass.
`default_nettype none

`include "trilinear_table_interpolator_top_defines.svh"

module trilinear_table_interpolator_top #(
  parameter int unsigned DIM_X     = trilin_pkg::DIM_X_DEF,
  parameter int unsigned DIM_Y     = trilin_pkg::DIM_Y_DEF,
  parameter int unsigned DIM_Z     = trilin_pkg::DIM_Z_DEF,
  parameter int unsigned FRAC_BITS = trilin_pkg::FRAC_BITS_DEF
) (
  input  wire logic                                    clk_i,
  input  wire logic                                    rst_ni,
  input  wire logic                                    in_valid_i,
  output logic                                         in_ready_o,
  input  wire logic                                    operation_i,
  input  wire logic        [trilin_pkg::IDX_W-1:0]     index_x_i,
  input  wire logic        [trilin_pkg::IDX_W-1:0]     index_y_i,
  input  wire logic        [trilin_pkg::IDX_W-1:0]     index_z_i,
  input  wire logic signed [trilin_pkg::VAL_W-1:0]     entry_value_i,
  input  wire logic        [trilin_pkg::FRAC_IN_W-1:0] frac_x_i,
  input  wire logic        [trilin_pkg::FRAC_IN_W-1:0] frac_y_i,
  input  wire logic        [trilin_pkg::FRAC_IN_W-1:0] frac_z_i,
  output logic                                         out_valid_o,
  input  wire logic                                    out_ready_i,
  output logic signed      [trilin_pkg::VAL_W-1:0]     result_value_o,
  output logic                                         index_error_o
);

  import trilin_pkg::*;

  localparam int unsigned NST = 7;
  localparam int unsigned FW  = FRAC_BITS + 1;
  localparam int unsigned CW  = (FW > FRAC_IN_W) ? FW : FRAC_IN_W;

  localparam int unsigned XAW = (DIM_X > (1 << IDX_W)) ? IDX_W : $clog2(DIM_X);
  localparam int unsigned YAW = (DIM_Y > (1 << IDX_W)) ? IDX_W : $clog2(DIM_Y);
  localparam int unsigned ZAW = (DIM_Z > (1 << IDX_W)) ? IDX_W : $clog2(DIM_Z);
  localparam int unsigned XBW = (XAW > 1) ? XAW - 1 : 1;
  localparam int unsigned YBW = (YAW > 1) ? YAW - 1 : 1;
  localparam int unsigned ZBW = (ZAW > 1) ? ZAW - 1 : 1;
  localparam int unsigned AW  = XBW + YBW + ZBW;
  localparam int unsigned BANK_DEPTH = 1 << AW;

  function automatic logic [FW-1:0] clamp_frac(input logic [FRAC_IN_W-1:0] f);
    logic [CW-1:0] ext;
    logic [CW-1:0] one;
    ext = CW'(f);
    one = CW'(1) << FRAC_BITS;
    return (ext > one) ? FW'(one) : FW'(ext);
  endfunction

  function automatic logic [IDX_W-1:0] half_idx(input logic [IDX_W-1:0] idx, input logic par);
    logic [IDX_W-1:0] base;
    base = (idx[0] == par) ? idx : idx - IDX_W'(1);
    return base >> 1;
  endfunction

  logic [NST:1] v_q;
  logic [NST:1] stage_en;
  logic [NST:1] err_q;
  logic [2:0]   par_q;
  logic [FW-1:0] fx_q;
  logic [FW-1:0] fy_q [1:3];
  logic [FW-1:0] fz_q [1:5];

  logic          accept;
  logic          is_query;
  logic          query_err;
  logic          wr_fire;
  logic [2:0]    wr_bank;
  logic [IDX_W-1:0] wx_half;
  logic [IDX_W-1:0] wy_half;
  logic [IDX_W-1:0] wz_half;
  logic [AW-1:0] wr_addr;
  logic [NUM_BANKS-1:0] bank_we;
  logic [AW-1:0] rd_addr [NUM_BANKS];
  logic [VAL_W-1:0] rdata [NUM_BANKS];

  logic signed [VAL_W-1:0] cx_a [4];
  logic signed [VAL_W-1:0] cx_b [4];
  logic signed [VAL_W-1:0] cx_res [4];
  logic signed [VAL_W-1:0] cy_res [2];
  logic signed [VAL_W-1:0] cz_res;

  always_comb begin
    stage_en[NST] = !v_q[NST] || out_ready_i;
    for (int k = NST - 1; k >= 1; k--) begin
      stage_en[k] = !v_q[k] || stage_en[k+1];
    end
  end

  assign in_ready_o = stage_en[1];
  assign accept     = in_valid_i && in_ready_o;
  assign is_query   = (operation_i == OP_QUERY);

  assign query_err = (index_x_i == '0) || (index_y_i == '0) || (index_z_i == '0) ||
                     (32'(index_x_i) >= DIM_X) || (32'(index_y_i) >= DIM_Y) ||
                     (32'(index_z_i) >= DIM_Z);

  assign wr_fire = accept && (operation_i == OP_WRITE) && (32'(index_x_i) < DIM_X) &&
                   (32'(index_y_i) < DIM_Y) && (32'(index_z_i) < DIM_Z);
  assign wr_bank = {index_x_i[0], index_y_i[0], index_z_i[0]};
  assign wx_half = index_x_i >> 1;
  assign wy_half = index_y_i >> 1;
  assign wz_half = index_z_i >> 1;
  assign wr_addr = {wx_half[XBW-1:0], wy_half[YBW-1:0], wz_half[ZBW-1:0]};

  always_comb begin
    logic [IDX_W-1:0] hx;
    logic [IDX_W-1:0] hy;
    logic [IDX_W-1:0] hz;
    logic [2:0]       bk;
    for (int b = 0; b < NUM_BANKS; b++) begin
      bk = 3'(b);
      hx = half_idx(index_x_i, bk[2]);
      hy = half_idx(index_y_i, bk[1]);
      hz = half_idx(index_z_i, bk[0]);
      rd_addr[b] = {hx[XBW-1:0], hy[YBW-1:0], hz[ZBW-1:0]};
    end
  end

  for (genvar b = 0; b < NUM_BANKS; b++) begin : g_bank
    localparam logic [2:0] BK = 3'(b);
    assign bank_we[b] = wr_fire && (wr_bank == BK);
    trilin_ram #(
      .WIDTH (VAL_W),
      .DEPTH (BANK_DEPTH)
    ) u_ram (
      .clk_i   (clk_i),
      .we_i    (bank_we[b]),
      .waddr_i (wr_addr),
      .wdata_i (entry_value_i),
      .re_i    (stage_en[1]),
      .raddr_i (rd_addr[b]),
      .rdata_o (rdata[b])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (stage_en[1]) begin
        v_q[1] <= in_valid_i && is_query;
      end
      for (int k = 2; k <= NST; k++) begin
        if (stage_en[k]) begin
          v_q[k] <= v_q[k-1];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (stage_en[1]) begin
      err_q[1] <= query_err;
      par_q    <= {index_x_i[0], index_y_i[0], index_z_i[0]};
      fx_q     <= clamp_frac(frac_x_i);
      fy_q[1]  <= clamp_frac(frac_y_i);
      fz_q[1]  <= clamp_frac(frac_z_i);
    end
    for (int k = 2; k <= NST; k++) begin
      if (stage_en[k]) begin
        err_q[k] <= err_q[k-1];
      end
    end
    for (int k = 2; k <= 3; k++) begin
      if (stage_en[k]) begin
        fy_q[k] <= fy_q[k-1];
      end
    end
    for (int k = 2; k <= 5; k++) begin
      if (stage_en[k]) begin
        fz_q[k] <= fz_q[k-1];
      end
    end
  end

  always_comb begin
    logic [1:0] jj;
    logic [2:0] bank_lo;
    logic [2:0] bank_hi;
    for (int j = 0; j < 4; j++) begin
      jj      = 2'(j);
      bank_lo = {~par_q[2], par_q[1] ~^ jj[0], par_q[0] ~^ jj[1]};
      bank_hi = { par_q[2], par_q[1] ~^ jj[0], par_q[0] ~^ jj[1]};
      cx_a[j] = rdata[bank_lo];
      cx_b[j] = rdata[bank_hi];
    end
  end

  for (genvar j = 0; j < 4; j++) begin : g_xblend
    trilin_blend #(
      .FRAC_BITS (FRAC_BITS)
    ) u_blend (
      .clk_i    (clk_i),
      .mul_en_i (stage_en[2]),
      .rnd_en_i (stage_en[3]),
      .a_i      (cx_a[j]),
      .b_i      (cx_b[j]),
      .frac_i   (fx_q),
      .result_o (cx_res[j])
    );
  end

  for (genvar j = 0; j < 2; j++) begin : g_yblend
    trilin_blend #(
      .FRAC_BITS (FRAC_BITS)
    ) u_blend (
      .clk_i    (clk_i),
      .mul_en_i (stage_en[4]),
      .rnd_en_i (stage_en[5]),
      .a_i      (cx_res[2*j]),
      .b_i      (cx_res[2*j+1]),
      .frac_i   (fy_q[3]),
      .result_o (cy_res[j])
    );
  end

  trilin_blend #(
    .FRAC_BITS (FRAC_BITS)
  ) u_zblend (
    .clk_i    (clk_i),
    .mul_en_i (stage_en[6]),
    .rnd_en_i (stage_en[7]),
    .a_i      (cy_res[0]),
    .b_i      (cy_res[1]),
    .frac_i   (fz_q[5]),
    .result_o (cz_res)
  );

  assign out_valid_o    = v_q[NST];
  assign index_error_o  = err_q[NST];
  assign result_value_o = err_q[NST] ? '0 : cz_res;

  `TRI_ASSERT_I(a_write_no_result, accept && (operation_i == OP_WRITE) |=> !v_q[1], "Write request entered the pipeline")
  `TRI_ASSERT_I(a_query_enters, accept && is_query |=> v_q[1], "Query request was dropped at entry")
  `TRI_ASSERT_I(a_stage_advance, v_q[1] && stage_en[2] |=> v_q[2], "Query was lost between the bank read and the x blend")
  `TRI_ASSERT_I(a_error_zero, out_valid_o && index_error_o |-> (result_value_o == '0), "Index error result is not zero")

endmodule

`default_nettype wire

>>> verif/trilinear_table_interpolator_checker.sv
`timescale 1ns / 1ps
// Checker for the trilinear table interpolator: mirrors the table from accepted write requests,
// predicts each query result and compares it with the result channel in order.
// Depends on trilin_pkg for widths, defaults and operation codes.

module trilinear_table_interpolator_checker
  import trilin_pkg::*;
#(
  parameter int unsigned FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  input  logic                        in_ready_i,
  input  logic                        operation_i,
  input  logic        [IDX_W-1:0]     index_x_i,
  input  logic        [IDX_W-1:0]     index_y_i,
  input  logic        [IDX_W-1:0]     index_z_i,
  input  logic signed [VAL_W-1:0]     entry_value_i,
  input  logic        [FRAC_IN_W-1:0] frac_x_i,
  input  logic        [FRAC_IN_W-1:0] frac_y_i,
  input  logic        [FRAC_IN_W-1:0] frac_z_i,
  input  logic                        out_valid_i,
  input  logic                        out_ready_i,
  input  logic signed [VAL_W-1:0]     result_value_i,
  input  logic                        index_error_i,
  output int unsigned                 pending_o,
  output int unsigned                 errors_o
);

  typedef struct packed {
    logic signed [VAL_W-1:0] value;
    logic                    index_error;
  } interp_result_t;

  localparam longint FRAC_ONE = longint'(1) << FRAC_BITS;
  localparam longint SAT_MAX  = 64'sd2147483647;
  localparam longint SAT_MIN  = -64'sd2147483648;

  logic signed [VAL_W-1:0] table_mirror [0:4095];
  interp_result_t          expected_results [$];
  int unsigned             pending_count  = 0;
  int unsigned             mismatch_count = 0;

  assign pending_o = pending_count;
  assign errors_o  = mismatch_count;

  function automatic longint frac_clamped(logic [FRAC_IN_W-1:0] f);
    if (longint'(f) > FRAC_ONE) begin
      return FRAC_ONE;
    end
    return longint'(f);
  endfunction

  function automatic longint blend_q16(longint a, longint b, longint f);
    longint q;
    longint r;
    q = ((b - a) * f + (longint'(1) << (FRAC_BITS - 1))) >>> FRAC_BITS;
    r = a + q;
    if (r > SAT_MAX) begin
      r = SAT_MAX;
    end else if (r < SAT_MIN) begin
      r = SAT_MIN;
    end
    return r;
  endfunction

  function automatic longint entry_at(logic [IDX_W-1:0] x, logic [IDX_W-1:0] y,
                                      logic [IDX_W-1:0] z);
    return longint'(table_mirror[{x, y, z}]);
  endfunction

  function automatic interp_result_t predict_query(
    logic [IDX_W-1:0] x, logic [IDX_W-1:0] y, logic [IDX_W-1:0] z,
    logic [FRAC_IN_W-1:0] fx_raw, logic [FRAC_IN_W-1:0] fy_raw, logic [FRAC_IN_W-1:0] fz_raw
  );
    interp_result_t   res;
    logic [IDX_W-1:0] x0, y0, z0;
    longint           fx, fy, fz, c00, c10, c01, c11, c0, c1, r;
    if (x == 0 || y == 0 || z == 0 || x >= DIM_X_DEF || y >= DIM_Y_DEF || z >= DIM_Z_DEF) begin
      res.value       = '0;
      res.index_error = 1'b1;
      return res;
    end
    fx  = frac_clamped(fx_raw);
    fy  = frac_clamped(fy_raw);
    fz  = frac_clamped(fz_raw);
    x0  = x - 4'd1;
    y0  = y - 4'd1;
    z0  = z - 4'd1;
    c00 = blend_q16(entry_at(x0, y0, z0), entry_at(x, y0, z0), fx);
    c10 = blend_q16(entry_at(x0, y, z0), entry_at(x, y, z0), fx);
    c01 = blend_q16(entry_at(x0, y0, z), entry_at(x, y0, z), fx);
    c11 = blend_q16(entry_at(x0, y, z), entry_at(x, y, z), fx);
    c0  = blend_q16(c00, c10, fy);
    c1  = blend_q16(c01, c11, fy);
    r   = blend_q16(c0, c1, fz);
    res.value       = r[VAL_W-1:0];
    res.index_error = 1'b0;
    return res;
  endfunction

  always @(posedge clk_i) begin
    interp_result_t oldest;
    if (rst_ni) begin
      if (out_valid_i && out_ready_i) begin
        if (expected_results.size() == 0) begin
          $error("result with no query pending: result_value %0d, index_error %0d",
                 result_value_i, index_error_i);
          mismatch_count++;
        end else begin
          oldest = expected_results.pop_front();
          pending_count--;
          if (result_value_i !== oldest.value) begin
            $error("result_value: expected %0d, actual %0d", oldest.value, result_value_i);
            mismatch_count++;
          end
          if (index_error_i !== oldest.index_error) begin
            $error("index_error: expected %0d, actual %0d", oldest.index_error,
                   index_error_i);
            mismatch_count++;
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        if (operation_i == OP_WRITE) begin
          table_mirror[{index_x_i, index_y_i, index_z_i}] = entry_value_i;
        end else begin
          expected_results.push_back(predict_query(index_x_i, index_y_i, index_z_i,
                                                   frac_x_i, frac_y_i, frac_z_i));
          pending_count++;
        end
      end
    end
  end

endmodule

>>> verif/trilinear_table_interpolator_top_tb.sv
`timescale 1ns / 1ps
// Testbench top for the trilinear table interpolator: drives write and query requests with
// random gaps and output stalls, and reports the verdict from the checker's mismatch count and a stall watchdog.
// Depends on trilin_pkg, the interpolator RTL and trilinear_table_interpolator_checker.

module trilinear_table_interpolator_top_tb;
  import trilin_pkg::*;

  localparam int unsigned STALL_LIMIT  = 4000;
  localparam int unsigned ITEM_TARGET  = 2025;
  localparam int unsigned RX_HOLD_LEN  = 300;
  localparam logic [FRAC_IN_W-1:0] FRAC_ONE = 17'h10000;
  localparam logic [7:0][VAL_W-1:0] CORNER_SEEDS = {
    32'h12345678, 32'hffff0000, 32'h00010000, 32'h00000001,
    32'hffffffff, 32'h00000000, 32'h80000000, 32'h7fffffff
  };

  logic                        clk_i;
  logic                        rst_ni;
  logic                        in_valid_i;
  logic                        in_ready_o;
  logic                        operation_i;
  logic        [IDX_W-1:0]     index_x_i;
  logic        [IDX_W-1:0]     index_y_i;
  logic        [IDX_W-1:0]     index_z_i;
  logic signed [VAL_W-1:0]     entry_value_i;
  logic        [FRAC_IN_W-1:0] frac_x_i;
  logic        [FRAC_IN_W-1:0] frac_y_i;
  logic        [FRAC_IN_W-1:0] frac_z_i;
  logic                        out_valid_o;
  logic                        out_ready_i;
  logic signed [VAL_W-1:0]     result_value_o;
  logic                        index_error_o;

  int unsigned pending_results;
  int unsigned mismatches;
  int unsigned items_sent   = 0;
  int unsigned stall_cycles = 0;
  int unsigned rx_hold_len  = 0;
  bit          tx_no_idle   = 1'b0;
  bit          rx_no_idle   = 1'b0;
  bit          loaded [0:4095];

  trilinear_table_interpolator_top u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .operation_i    (operation_i),
    .index_x_i      (index_x_i),
    .index_y_i      (index_y_i),
    .index_z_i      (index_z_i),
    .entry_value_i  (entry_value_i),
    .frac_x_i       (frac_x_i),
    .frac_y_i       (frac_y_i),
    .frac_z_i       (frac_z_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .result_value_o (result_value_o),
    .index_error_o  (index_error_o)
  );

  trilinear_table_interpolator_checker u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_i     (in_ready_o),
    .operation_i    (operation_i),
    .index_x_i      (index_x_i),
    .index_y_i      (index_y_i),
    .index_z_i      (index_z_i),
    .entry_value_i  (entry_value_i),
    .frac_x_i       (frac_x_i),
    .frac_y_i       (frac_y_i),
    .frac_z_i       (frac_z_i),
    .out_valid_i    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .result_value_i (result_value_o),
    .index_error_i  (index_error_o),
    .pending_o      (pending_results),
    .errors_o       (mismatches)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  function automatic logic signed [VAL_W-1:0] rand_entry();
    case ($urandom_range(0, 5))
      0:       return 32'sh7fffffff;
      1:       return 32'sh80000000;
      2:       return $urandom_range(0, 131071) - 65536;
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [FRAC_IN_W-1:0] rand_frac();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return FRAC_ONE;
      2:       return FRAC_IN_W'($urandom_range(65537, 131071));
      3:       return 17'h08000;
      default: return FRAC_IN_W'($urandom_range(0, 65536));
    endcase
  endfunction

  function automatic logic [IDX_W-1:0] rand_idx(input int unsigned lo);
    return IDX_W'($urandom_range(lo, 15));
  endfunction

  task automatic send_request(input logic op, input logic [IDX_W-1:0] x, y, z,
                              input logic signed [VAL_W-1:0] value,
                              input logic [FRAC_IN_W-1:0] fx, fy, fz);
    int unsigned gap;
    gap = tx_no_idle ? 0 : $urandom_range(0, 13);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    operation_i   <= op;
    index_x_i     <= x;
    index_y_i     <= y;
    index_z_i     <= z;
    entry_value_i <= value;
    frac_x_i      <= fx;
    frac_y_i      <= fy;
    frac_z_i      <= fz;
    do @(posedge clk_i); while (!in_ready_o);
    if (op == OP_WRITE) begin
      loaded[{x, y, z}] = 1'b1;
    end
    items_sent++;
  endtask

  // Loads any missing corner of the cell below the upper corner, rewrites some at random,
  // then queries the cell one to three times.
  task automatic query_cube(input logic [IDX_W-1:0] x, y, z);
    logic [IDX_W-1:0] cx, cy, cz;
    int unsigned      n;
    for (int i = 0; i < 8; i++) begin
      cx = i[2] ? x : x - 4'd1;
      cy = i[1] ? y : y - 4'd1;
      cz = i[0] ? z : z - 4'd1;
      if (!loaded[{cx, cy, cz}] || $urandom_range(0, 3) == 0) begin
        send_request(OP_WRITE, cx, cy, cz, rand_entry(), rand_frac(), rand_frac(), rand_frac());
      end
    end
    n = $urandom_range(1, 3);
    repeat (n) begin
      send_request(OP_QUERY, x, y, z, rand_entry(), rand_frac(), rand_frac(), rand_frac());
    end
  endtask

  task automatic drain_results();
    in_valid_i <= 1'b0;
    do @(negedge clk_i); while (pending_results != 0);
    @(posedge clk_i);
  endtask

  initial begin
    logic [IDX_W-1:0] qx, qy, qz;
    int unsigned      next_shuffle;
    bit               pressure_done;
    next_shuffle  = 150;
    pressure_done = 1'b0;
    in_valid_i    <= 1'b0;
    operation_i   <= OP_WRITE;
    index_x_i     <= '0;
    index_y_i     <= '0;
    index_z_i     <= '0;
    entry_value_i <= '0;
    frac_x_i      <= '0;
    frac_y_i      <= '0;
    frac_z_i      <= '0;
    rst_ni        <= 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < 8; i++) begin
      send_request(OP_WRITE, IDX_W'(i[2]), IDX_W'(i[1]), IDX_W'(i[0]), CORNER_SEEDS[i],
                   rand_frac(), rand_frac(), rand_frac());
    end
    send_request(OP_QUERY, 4'd1, 4'd1, 4'd1, rand_entry(), '0, '0, '0);
    send_request(OP_QUERY, 4'd1, 4'd1, 4'd1, rand_entry(), FRAC_ONE, FRAC_ONE, FRAC_ONE);
    send_request(OP_QUERY, 4'd1, 4'd1, 4'd1, rand_entry(), 17'h1ffff, 17'h1ffff, 17'h1ffff);
    send_request(OP_QUERY, 4'd1, 4'd1, 4'd1, rand_entry(), 17'h08000, 17'h00001, 17'h0ffff);
    send_request(OP_QUERY, 4'd1, 4'd1, 4'd1, rand_entry(), FRAC_ONE, '0, 17'h08000);
    send_request(OP_QUERY, 4'd0, 4'd1, 4'd1, rand_entry(), rand_frac(), rand_frac(), rand_frac());
    send_request(OP_QUERY, 4'd1, 4'd0, 4'd1, rand_entry(), rand_frac(), rand_frac(), rand_frac());
    send_request(OP_QUERY, 4'd1, 4'd1, 4'd0, rand_entry(), rand_frac(), rand_frac(), rand_frac());
    for (int i = 0; i < 8; i++) begin
      send_request(OP_WRITE, 4'd14 + IDX_W'(i[2]), 4'd14 + IDX_W'(i[1]),
                   4'd14 + IDX_W'(i[0]), rand_entry(),
                   rand_frac(), rand_frac(), rand_frac());
    end
    send_request(OP_QUERY, 4'd15, 4'd15, 4'd15, rand_entry(), rand_frac(), rand_frac(),
                 rand_frac());
    drain_results();

    while (items_sent < ITEM_TARGET) begin
      if (items_sent >= next_shuffle) begin
        tx_no_idle   = ($urandom_range(0, 3) == 0);
        rx_no_idle   = ($urandom_range(0, 3) == 0);
        next_shuffle = next_shuffle + 150;
      end
      if (!pressure_done && items_sent >= ITEM_TARGET / 2) begin
        // The receiver holds off while the sender streams, so the pipeline backs up.
        drain_results();
        rx_hold_len = RX_HOLD_LEN;
        tx_no_idle  = 1'b1;
        repeat (20) begin
          query_cube(rand_idx(1), rand_idx(1), rand_idx(1));
        end
        drain_results();
        pressure_done = 1'b1;
      end
      case ($urandom_range(0, 9))
        7: begin
          send_request(OP_WRITE, rand_idx(0), rand_idx(0), rand_idx(0), rand_entry(),
                       rand_frac(), rand_frac(), rand_frac());
        end
        8, 9: begin
          qx = rand_idx(0);
          qy = rand_idx(0);
          qz = rand_idx(0);
          case ($urandom_range(0, 2))
            0:       qx = '0;
            1:       qy = '0;
            default: qz = '0;
          endcase
          send_request(OP_QUERY, qx, qy, qz, rand_entry(), rand_frac(), rand_frac(),
                       rand_frac());
        end
        default: begin
          query_cube(rand_idx(1), rand_idx(1), rand_idx(1));
        end
      endcase
    end

    drain_results();
    repeat (16) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    int unsigned gap;
    int unsigned hold;
    out_ready_i <= 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if (rx_hold_len != 0) begin
        hold        = rx_hold_len;
        rx_hold_len = 0;
        out_ready_i <= 1'b0;
        repeat (hold) @(posedge clk_i);
      end
      gap = rx_no_idle ? 0 : $urandom_range(0, 13);
      if (gap != 0) begin
        out_ready_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= STALL_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

endmodule
